// File: rtl/similarity_transform_point_core_macros.svh
// Assertion helpers for the similarity transform core.
// Both use the core's clk and arst_n and are disabled while reset is asserted.
`ifndef SIMILARITY_TRANSFORM_POINT_CORE_MACROS_SVH
`define SIMILARITY_TRANSFORM_POINT_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STP_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define STP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/stp_pkg.sv
package stp_pkg;

	// Number formats.
	localparam int COORD_W    = 32;
	localparam int COORD_FRAC = 16;
	localparam int ROT_FRAC   = 30;
	localparam int ROT_W      = ROT_FRAC + 2;
	localparam int SCALE_W    = COORD_W;

	// Configuration port.
	localparam int NUM_REGS   = 8;
	localparam int CFG_IDX_W  = $clog2(NUM_REGS);
	localparam int CFG_DATA_W = (COORD_W > ROT_W) ? COORD_W : ROT_W;

	localparam logic [CFG_IDX_W-1:0] REG_SCALE   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_ROT_W   = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_ROT_X   = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_ROT_Y   = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_ROT_Z   = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X = CFG_IDX_W'(5);
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y = CFG_IDX_W'(6);
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Z = CFG_IDX_W'(7);

	// Datapath widths. Matrix entries are split into two limbs for the
	// matrix-vector products, and row sums into three limbs for the scale.
	localparam int PROD_W  = 2 * ROT_W;
	localparam int MAT_W   = PROD_W + 2;
	localparam int SPLIT_W = (MAT_W + 1) / 2;
	localparam int MHI_W   = MAT_W - SPLIT_W;
	localparam int PHI_W   = MHI_W + COORD_W;
	localparam int PLO_W   = SPLIT_W + 1 + COORD_W;
	localparam int ROW_W   = MAT_W + COORD_W + 2;
	localparam int A2_W    = ROW_W - 2 * SPLIT_W;
	localparam int UP_W    = SPLIT_W + SCALE_W;
	localparam int SP2_W   = A2_W + SCALE_W + 1;
	localparam int TOT_W   = ROW_W + SCALE_W + 2;
	localparam int RND_SH  = 2 * ROT_FRAC + COORD_FRAC;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [ROT_W-1:0]   rot_t;
	typedef logic        [SCALE_W-1:0] scale_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [MAT_W-1:0]   mat_entry_t;
	typedef logic signed [ROW_W-1:0]   row_t;
	typedef logic signed [TOT_W-1:0]   tot_t;

	localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
	localparam scale_t SCALE_ONE = SCALE_W'(1) << COORD_FRAC;
	localparam rot_t   ROT_ONE   = ROT_W'(1) << ROT_FRAC;

	typedef struct packed {
		coord_t point_x;
		coord_t point_y;
		coord_t point_z;
	} point_t;

	typedef struct packed {
		coord_t out_x;
		coord_t out_y;
		coord_t out_z;
		logic   saturated;
	} result_t;

	typedef struct packed {
		scale_t scale_factor;
		rot_t   rot_w;
		rot_t   rot_x;
		rot_t   rot_y;
		rot_t   rot_z;
		coord_t shift_x;
		coord_t shift_y;
		coord_t shift_z;
	} cfg_t;

endpackage

// File: rtl/stp_cfg_regs.sv
module stp_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [stp_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [stp_pkg::CFG_DATA_W-1:0] cfg_data,
	output stp_pkg::cfg_t                  cfg
);
	import stp_pkg::*;

	cfg_t cfg_q;

	// Register file: identity rotation, unit scale, no translation after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scale_factor <= SCALE_ONE;
			cfg_q.rot_w        <= ROT_ONE;
			cfg_q.rot_x        <= '0;
			cfg_q.rot_y        <= '0;
			cfg_q.rot_z        <= '0;
			cfg_q.shift_x      <= '0;
			cfg_q.shift_y      <= '0;
			cfg_q.shift_z      <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_SCALE:   cfg_q.scale_factor <= cfg_data[SCALE_W-1:0];
				REG_ROT_W:   cfg_q.rot_w        <= cfg_data[ROT_W-1:0];
				REG_ROT_X:   cfg_q.rot_x        <= cfg_data[ROT_W-1:0];
				REG_ROT_Y:   cfg_q.rot_y        <= cfg_data[ROT_W-1:0];
				REG_ROT_Z:   cfg_q.rot_z        <= cfg_data[ROT_W-1:0];
				REG_SHIFT_X: cfg_q.shift_x      <= cfg_data[COORD_W-1:0];
				REG_SHIFT_Y: cfg_q.shift_y      <= cfg_data[COORD_W-1:0];
				REG_SHIFT_Z: cfg_q.shift_z      <= cfg_data[COORD_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/stp_rot_matrix.sv
module stp_rot_matrix (
	input  logic                clk,
	input  logic                arst_n,
	input  stp_pkg::cfg_t       cfg,
	input  logic                valid_s1,
	input  stp_pkg::point_t     point_s1,
	output logic                valid_s3,
	output stp_pkg::point_t     point_s3,
	output stp_pkg::mat_entry_t matrix_s3 [3][3]
);
	import stp_pkg::*;

	logic   valid_s2;
	point_t point_s2;
	prod_t  ww_s2, xx_s2, yy_s2, zz_s2, xy_s2, xz_s2, yz_s2, wx_s2, wy_s2, wz_s2;

	mat_entry_t ww, xx, yy, zz, xy, xz, yz, wx, wy, wz;

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Stage 2: the ten quaternion component products.
	always_ff @(posedge clk) begin
		point_s2 <= point_s1;
		ww_s2    <= PROD_W'(cfg.rot_w) * PROD_W'(cfg.rot_w);
		xx_s2    <= PROD_W'(cfg.rot_x) * PROD_W'(cfg.rot_x);
		yy_s2    <= PROD_W'(cfg.rot_y) * PROD_W'(cfg.rot_y);
		zz_s2    <= PROD_W'(cfg.rot_z) * PROD_W'(cfg.rot_z);
		xy_s2    <= PROD_W'(cfg.rot_x) * PROD_W'(cfg.rot_y);
		xz_s2    <= PROD_W'(cfg.rot_x) * PROD_W'(cfg.rot_z);
		yz_s2    <= PROD_W'(cfg.rot_y) * PROD_W'(cfg.rot_z);
		wx_s2    <= PROD_W'(cfg.rot_w) * PROD_W'(cfg.rot_x);
		wy_s2    <= PROD_W'(cfg.rot_w) * PROD_W'(cfg.rot_y);
		wz_s2    <= PROD_W'(cfg.rot_w) * PROD_W'(cfg.rot_z);
	end

	// Sign-extend the products to the matrix entry width.
	always_comb begin
		ww = MAT_W'(ww_s2);
		xx = MAT_W'(xx_s2);
		yy = MAT_W'(yy_s2);
		zz = MAT_W'(zz_s2);
		xy = MAT_W'(xy_s2);
		xz = MAT_W'(xz_s2);
		yz = MAT_W'(yz_s2);
		wx = MAT_W'(wx_s2);
		wy = MAT_W'(wy_s2);
		wz = MAT_W'(wz_s2);
	end

	// Stage 3: rotation matrix of the unnormalized quaternion.
	always_ff @(posedge clk) begin
		point_s3        <= point_s2;
		matrix_s3[0][0] <= ww + xx - yy - zz;
		matrix_s3[1][1] <= ww - xx + yy - zz;
		matrix_s3[2][2] <= ww - xx - yy + zz;
		matrix_s3[0][1] <= (xy - wz) <<< 1;
		matrix_s3[0][2] <= (xz + wy) <<< 1;
		matrix_s3[1][0] <= (xy + wz) <<< 1;
		matrix_s3[1][2] <= (yz - wx) <<< 1;
		matrix_s3[2][0] <= (xz - wy) <<< 1;
		matrix_s3[2][1] <= (yz + wx) <<< 1;
	end

endmodule

// File: rtl/stp_mat_vec.sv
module stp_mat_vec (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_s3,
	input  stp_pkg::point_t     point_s3,
	input  stp_pkg::mat_entry_t matrix_s3 [3][3],
	output logic                valid_s5,
	output stp_pkg::row_t       row_s5 [3]
);
	import stp_pkg::*;

	logic                    valid_s4;
	logic signed [PHI_W-1:0] pp_hi_s4 [3][3];
	logic signed [PLO_W-1:0] pp_lo_s4 [3][3];

	coord_t pv [3];
	row_t   row_sum [3];

	assign pv[0] = point_s3.point_x;
	assign pv[1] = point_s3.point_y;
	assign pv[2] = point_s3.point_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// Stage 4: each entry times its coordinate, as a signed high limb and an
	// unsigned low limb.
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				pp_hi_s4[i][j] <= PHI_W'($signed(matrix_s3[i][j][MAT_W-1:SPLIT_W]))
					* PHI_W'(pv[j]);
				pp_lo_s4[i][j] <= PLO_W'($signed({1'b0, matrix_s3[i][j][SPLIT_W-1:0]}))
					* PLO_W'(pv[j]);
			end
		end
	end

	// Recombine the limbs and sum along each row.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			row_sum[i] = '0;
			for (int j = 0; j < 3; j++) begin
				row_sum[i] = row_sum[i] + (ROW_W'(pp_hi_s4[i][j]) <<< SPLIT_W)
					+ ROW_W'(pp_lo_s4[i][j]);
			end
		end
	end

	// Stage 5: rotated point, exact.
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			row_s5[i] <= row_sum[i];
		end
	end

endmodule

// File: rtl/stp_scale_round.sv
module stp_scale_round (
	input  logic              clk,
	input  logic              arst_n,
	input  stp_pkg::cfg_t     cfg,
	input  logic              valid_s5,
	input  stp_pkg::row_t     row_s5 [3],
	output logic              valid_s8,
	output stp_pkg::result_t  result_s8
);
	import stp_pkg::*;

	localparam tot_t RND_HALF = TOT_W'(1) << (RND_SH - 1);

	logic                    valid_s6, valid_s7;
	logic        [UP_W-1:0]  sp0_s6 [3];
	logic        [UP_W-1:0]  sp1_s6 [3];
	logic signed [SP2_W-1:0] sp2_s6 [3];
	tot_t                    prod_s7 [3];

	coord_t shift_v [3];
	tot_t   sum [3];
	coord_t clip_val [3];
	logic   clip_hit [3];

	assign shift_v[0] = cfg.shift_x;
	assign shift_v[1] = cfg.shift_y;
	assign shift_v[2] = cfg.shift_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
		end else begin
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
			valid_s8 <= valid_s7;
		end
	end

	// Stage 6: row sums times scale, one partial product per limb.
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sp0_s6[i] <= UP_W'(row_s5[i][SPLIT_W-1:0]) * UP_W'(cfg.scale_factor);
			sp1_s6[i] <= UP_W'(row_s5[i][2*SPLIT_W-1:SPLIT_W]) * UP_W'(cfg.scale_factor);
			sp2_s6[i] <= SP2_W'($signed(row_s5[i][ROW_W-1:2*SPLIT_W]))
				* SP2_W'($signed({1'b0, cfg.scale_factor}));
		end
	end

	// Stage 7: full scaled product.
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			prod_s7[i] <= (TOT_W'(sp2_s6[i]) <<< (2 * SPLIT_W))
				+ (TOT_W'(sp1_s6[i]) << SPLIT_W) + TOT_W'(sp0_s6[i]);
		end
	end

	// Add the aligned translation and one half, then clip the integer part.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sum[i] = prod_s7[i] + (TOT_W'(shift_v[i]) <<< RND_SH) + RND_HALF;
			clip_hit[i] = !((&sum[i][TOT_W-1:RND_SH+COORD_W-1])
				|| !(|sum[i][TOT_W-1:RND_SH+COORD_W-1]));
			if (!clip_hit[i]) begin
				clip_val[i] = sum[i][RND_SH+COORD_W-1:RND_SH];
			end else if (sum[i][TOT_W-1]) begin
				clip_val[i] = COORD_MIN;
			end else begin
				clip_val[i] = COORD_MAX;
			end
		end
	end

	// Stage 8: output register.
	always_ff @(posedge clk) begin
		result_s8.out_x     <= clip_val[0];
		result_s8.out_y     <= clip_val[1];
		result_s8.out_z     <= clip_val[2];
		result_s8.saturated <= clip_hit[0] | clip_hit[1] | clip_hit[2];
	end

endmodule

// File: rtl/similarity_transform_point_core.sv
// Transforms one 3D point per clock: out = scale * (q (0,p) conj(q)) + shift, in signed
// Q16.16 with a Q2.30 quaternion used as written (a non-unit q also scales by |q|^2).
// A point transfers at each rising edge with start high; busy stays low, so a new point
// may be offered in every cycle. Its result appears on result,
// marked by done for a single cycle, in order; the receiver cannot hold it off and must
// take it then. The pipeline has eight register stages: input,
// quaternion products, matrix, matrix-vector partial products, row sums, scale partial
// products, scale sum, and round-and-clip. Clipped coordinates set result.saturated.
// Write the configuration registers only while no point is in flight.
`include "similarity_transform_point_core_macros.svh"

module similarity_transform_point_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  stp_pkg::point_t                point,
	output logic                           done,
	output stp_pkg::result_t               result,
	input  logic                           cfg_we,
	input  logic [stp_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [stp_pkg::CFG_DATA_W-1:0] cfg_data
);
	import stp_pkg::*;

	cfg_t       cfg;
	logic       valid_s1, valid_s3, valid_s5, valid_s8;
	point_t     point_s1, point_s3;
	mat_entry_t matrix_s3 [3][3];
	row_t       row_s5 [3];
	result_t    result_s8;

	// The pipeline never stalls.
	assign busy = 1'b0;

	// Stage 1: input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		point_s1 <= point;
	end

	stp_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	stp_rot_matrix u_rot_matrix (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.valid_s1  (valid_s1),
		.point_s1  (point_s1),
		.valid_s3  (valid_s3),
		.point_s3  (point_s3),
		.matrix_s3 (matrix_s3)
	);

	stp_mat_vec u_mat_vec (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s3  (valid_s3),
		.point_s3  (point_s3),
		.matrix_s3 (matrix_s3),
		.valid_s5  (valid_s5),
		.row_s5    (row_s5)
	);

	stp_scale_round u_scale_round (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.valid_s5  (valid_s5),
		.row_s5    (row_s5),
		.valid_s8  (valid_s8),
		.result_s8 (result_s8)
	);

	assign done   = valid_s8;
	assign result = result_s8;

	// Every result traces back to an earlier point transfer.
	`STP_ASSERT_SAME(a_done_latency, done, $past(start && !busy, 8), "result without matching transfer")

	// A saturated result carries at least one coordinate at a range limit.
	`STP_ASSERT_SAME(a_sat_limit, done && result.saturated, (result.out_x == COORD_MAX || result.out_x == COORD_MIN || result.out_y == COORD_MAX || result.out_y == COORD_MIN || result.out_z == COORD_MAX || result.out_z == COORD_MIN), "saturated flag without clipped coordinate")

	// A transfer always reaches the rotation matrix stage, via the quaternion product stage.
	`STP_ASSERT_NEXT(a_s3_follows, valid_s1, ##1 valid_s3, "pipeline lost a point")

endmodule

// File: verif/similarity_transform_point_core_test.sv
module similarity_transform_point_core_test;
	import stp_pkg::*;

	typedef logic signed [255:0] wide_t;

	localparam coord_t UNIT_COORD = 32'sh0001_0000;
	localparam rot_t COS_45 = 32'sh2D41_3CCD;
	localparam rot_t ROT_MOST_NEG = 32'sh8000_0000;
	localparam rot_t ROT_MOST_POS = 32'sh7FFF_FFFF;
	localparam int QUIET_LIMIT = 2000;
	localparam int RANDOM_PHASES = 13;
	localparam int POINTS_PER_PHASE = 100;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	point_t point = '0;
	logic done;
	result_t result;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Points waiting to be offered, and transformed points still to come back.
	point_t points_to_send[$];
	result_t transformed_due[$];
	cfg_t xform_regs;
	bit gaps_on = 1'b1;
	int unsigned gap_left = 0;
	int unsigned error_count = 0;
	int unsigned quiet_cycles = 0;

	similarity_transform_point_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.point(point),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Clip an exact coordinate to the Q16.16 range and flag the clip.
	function automatic coord_t clip_coord(input wide_t v, inout logic clipped);
		wide_t hi;
		wide_t lo;
		hi = COORD_MAX;
		lo = COORD_MIN;
		if (v > hi) begin
			clipped = 1'b1;
			return COORD_MAX;
		end
		if (v < lo) begin
			clipped = 1'b1;
			return COORD_MIN;
		end
		return coord_t'(v);
	endfunction

	// Exact scale * (q (0,p) conj(q)) + shift, rounded half up once, then clipped.
	function automatic result_t transform_point(input point_t p, input cfg_t c);
		wide_t w, x, y, z, sc, acc, half;
		wide_t ww, xx, yy, zz, xy, xz, yz, wx, wy, wz;
		wide_t m [3][3];
		wide_t v [3];
		wide_t tr [3];
		coord_t res [3];
		logic clipped;
		result_t r;
		w = $signed(c.rot_w);
		x = $signed(c.rot_x);
		y = $signed(c.rot_y);
		z = $signed(c.rot_z);
		sc = c.scale_factor;
		v[0] = $signed(p.point_x);
		v[1] = $signed(p.point_y);
		v[2] = $signed(p.point_z);
		tr[0] = $signed(c.shift_x);
		tr[1] = $signed(c.shift_y);
		tr[2] = $signed(c.shift_z);
		ww = w * w; xx = x * x; yy = y * y; zz = z * z;
		xy = x * y; xz = x * z; yz = y * z;
		wx = w * x; wy = w * y; wz = w * z;
		// Rotation matrix of the unnormalized quaternion.
		m[0][0] = ww + xx - yy - zz;
		m[0][1] = (xy - wz) <<< 1;
		m[0][2] = (xz + wy) <<< 1;
		m[1][0] = (xy + wz) <<< 1;
		m[1][1] = ww - xx + yy - zz;
		m[1][2] = (yz - wx) <<< 1;
		m[2][0] = (xz - wy) <<< 1;
		m[2][1] = (yz + wx) <<< 1;
		m[2][2] = ww - xx - yy + zz;
		half = 1;
		half = half <<< (RND_SH - 1);
		clipped = 1'b0;
		for (int i = 0; i < 3; i++) begin
			acc = m[i][0] * v[0] + m[i][1] * v[1] + m[i][2] * v[2];
			acc = acc * sc;
			acc = acc + (tr[i] <<< RND_SH) + half;
			acc = acc >>> RND_SH;
			res[i] = clip_coord(acc, clipped);
		end
		r.out_x = res[0];
		r.out_y = res[1];
		r.out_z = res[2];
		r.saturated = clipped;
		return r;
	endfunction

	// Idle cycles after an offered point: mostly none or short, a few long.
	function automatic int unsigned next_gap();
		int unsigned r;
		if (!gaps_on) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 50) begin
			return 0;
		end
		if (r < 85) begin
			return $urandom_range(1, 3);
		end
		if (r < 96) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	// Coordinates: mostly moderate magnitudes, some full range, some extremes.
	function automatic coord_t rand_coord();
		coord_t v;
		case ($urandom_range(0, 15))
			0: begin
				case ($urandom_range(0, 4))
					0: v = COORD_MAX;
					1: v = COORD_MIN;
					2: v = '0;
					3: v = -1;
					default: v = UNIT_COORD;
				endcase
			end
			1, 2, 3: begin
				v = $urandom;
			end
			default: begin
				v = $urandom;
				v = v >>> $urandom_range(6, 24);
			end
		endcase
		return v;
	endfunction

	task automatic send_point(input coord_t x, input coord_t y, input coord_t z);
		point_t p;
		p.point_x = x;
		p.point_y = y;
		p.point_z = z;
		points_to_send.insert(points_to_send.size(), p);
	endtask

	// Block until every offered point has transferred and its result has come back.
	task automatic wait_idle();
		do @(negedge clk);
		while (points_to_send.size() != 0 || transformed_due.size() != 0 || start);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
	endtask

	// Load a full register set once the core is idle.
	task automatic program_regs(input cfg_t c);
		wait_idle();
		write_reg(REG_SCALE, c.scale_factor);
		write_reg(REG_ROT_W, c.rot_w);
		write_reg(REG_ROT_X, c.rot_x);
		write_reg(REG_ROT_Y, c.rot_y);
		write_reg(REG_ROT_Z, c.rot_z);
		write_reg(REG_SHIFT_X, c.shift_x);
		write_reg(REG_SHIFT_Y, c.shift_y);
		write_reg(REG_SHIFT_Z, c.shift_z);
		@(posedge clk);
		cfg_we <= 1'b0;
		xform_regs = c;
		@(negedge clk);
	endtask

	// Driver: offers queued points and predicts each one on its transfer.
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
			gap_left <= 0;
		end else begin
			if (start && !busy) begin
				transformed_due.insert(transformed_due.size(),
					transform_point(point, xform_regs));
			end
			if (!(start && busy)) begin
				if (gap_left != 0) begin
					start <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (points_to_send.size() != 0) begin
					start <= 1'b1;
					point <= points_to_send.pop_front();
					gap_left <= next_gap();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: every result transfer is checked against the oldest prediction.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (transformed_due.size() == 0) begin
				error_count++;
				if (error_count <= 10) begin
					$display("unexpected result: x=%h y=%h z=%h sat=%b",
						result.out_x, result.out_y, result.out_z, result.saturated);
				end
			end else begin
				want = transformed_due.pop_front();
				if (result.out_x !== want.out_x || result.out_y !== want.out_y ||
						result.out_z !== want.out_z ||
						result.saturated !== want.saturated) begin
					error_count++;
					if (error_count <= 10) begin
						$display("mismatch: got x=%h y=%h z=%h sat=%b",
							result.out_x, result.out_y, result.out_z, result.saturated);
						$display("     expected x=%h y=%h z=%h sat=%b",
							want.out_x, want.out_y, want.out_z, want.saturated);
					end
				end
			end
		end
	end

	// Watchdog: too long without any transfer or register write ends the run.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done || cfg_we) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		cfg_t c;
		xform_regs = '0;
		xform_regs.scale_factor = SCALE_ONE;
		xform_regs.rot_w = ROT_ONE;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Identity after reset: extreme coordinates pass straight through.
		send_point('0, '0, '0);
		send_point(COORD_MAX, COORD_MAX, COORD_MAX);
		send_point(COORD_MIN, COORD_MIN, COORD_MIN);
		send_point(-1, -1, -1);
		send_point(UNIT_COORD, -UNIT_COORD, UNIT_COORD >>> 1);
		send_point(COORD_MAX, COORD_MIN, 1);

		// Half scale: exact halves round toward plus infinity.
		c = xform_regs;
		c.scale_factor = SCALE_ONE >> 1;
		program_regs(c);
		send_point(1, -1, 3);
		send_point(-3, COORD_MAX, COORD_MIN);

		// Zero scale leaves only the translation.
		c.scale_factor = '0;
		c.rot_w = $urandom;
		c.rot_x = $urandom;
		c.rot_y = $urandom;
		c.rot_z = $urandom;
		c.shift_x = $urandom;
		c.shift_y = $urandom;
		c.shift_z = $urandom;
		program_regs(c);
		send_point($urandom, $urandom, $urandom);
		send_point(COORD_MAX, COORD_MIN, COORD_MAX);

		// Zero quaternion also leaves only the translation.
		c.scale_factor = $urandom;
		c.rot_w = '0;
		c.rot_x = '0;
		c.rot_y = '0;
		c.rot_z = '0;
		c.shift_x = COORD_MAX;
		c.shift_y = COORD_MIN;
		c.shift_z = -1;
		program_regs(c);
		send_point($urandom, $urandom, $urandom);
		send_point(COORD_MIN, COORD_MIN, COORD_MIN);

		// Largest scale and most negative quaternion: heavy saturation.
		c.scale_factor = '1;
		c.rot_w = ROT_MOST_NEG;
		c.rot_x = ROT_MOST_NEG;
		c.rot_y = ROT_MOST_NEG;
		c.rot_z = ROT_MOST_NEG;
		c.shift_x = COORD_MAX;
		c.shift_y = COORD_MAX;
		c.shift_z = COORD_MAX;
		program_regs(c);
		send_point(COORD_MAX, COORD_MAX, COORD_MAX);
		send_point(COORD_MIN, COORD_MIN, COORD_MIN);
		send_point(1, '0, -1);

		// Most positive quaternion with the most negative translation.
		c.scale_factor = SCALE_ONE;
		c.rot_w = ROT_MOST_POS;
		c.rot_x = ROT_MOST_POS;
		c.rot_y = ROT_MOST_POS;
		c.rot_z = ROT_MOST_POS;
		c.shift_x = COORD_MIN;
		c.shift_y = COORD_MIN;
		c.shift_z = COORD_MIN;
		program_regs(c);
		send_point(UNIT_COORD, UNIT_COORD, UNIT_COORD);
		send_point(-1, '0, COORD_MAX);

		// Quarter turn about z, near unit norm, with a small translation.
		c.rot_w = COS_45;
		c.rot_x = '0;
		c.rot_y = '0;
		c.rot_z = COS_45;
		c.shift_x = UNIT_COORD;
		c.shift_y = '0;
		c.shift_z = -UNIT_COORD;
		program_regs(c);
		send_point(UNIT_COORD, '0, '0);
		send_point('0, UNIT_COORD, '0);
		send_point(COORD_MAX, '0, COORD_MIN);

		// Random settings: mostly scaled-down random quaternions and moderate scales.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case ($urandom_range(0, 9))
				0: c.scale_factor = $urandom;
				1: c.scale_factor = ($urandom_range(0, 1) == 0) ? 32'd1 : '1;
				default: c.scale_factor = $urandom_range(32'h0000_4000, 32'h0004_0000);
			endcase
			c.rot_w = $urandom;
			c.rot_x = $urandom;
			c.rot_y = $urandom;
			c.rot_z = $urandom;
			if ($urandom_range(0, 4) != 0) begin
				c.rot_w = c.rot_w >>> $urandom_range(1, 6);
				c.rot_x = c.rot_x >>> $urandom_range(1, 6);
				c.rot_y = c.rot_y >>> $urandom_range(1, 6);
				c.rot_z = c.rot_z >>> $urandom_range(1, 6);
			end
			c.shift_x = rand_coord();
			c.shift_y = rand_coord();
			c.shift_z = rand_coord();
			program_regs(c);
			gaps_on = ($urandom_range(0, 3) != 0);
			for (int k = 0; k < POINTS_PER_PHASE; k++) begin
				send_point(rand_coord(), rand_coord(), rand_coord());
			end
		end

		wait_idle();
		repeat (12) @(posedge clk);
		if (error_count == 0 && transformed_due.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// File: files.f
+incdir+rtl
rtl/stp_pkg.sv
rtl/stp_cfg_regs.sv
rtl/stp_rot_matrix.sv
rtl/stp_mat_vec.sv
rtl/stp_scale_round.sv
rtl/similarity_transform_point_core.sv
verif/similarity_transform_point_core_test.sv
